// File: design/jd2cal_pkg.sv
`timescale 1ns / 1ps

package jd2cal_pkg;

	localparam int unsigned PC_W = 7;
	typedef logic [PC_W-1:0] pc_t;

	// calendar constants
	localparam logic [31:0] JULIAN_LAST_DAY = 32'd2299160;
	localparam logic [31:0] JUL_CYCLE       = 32'd1461;
	localparam logic [31:0] GREG_SHIFT      = 32'd1721120;
	localparam logic [31:0] GREG_ERA        = 32'd146097;
	localparam logic [31:0] GREG_CENT       = 32'd36524;
	localparam logic [31:0] YEAR_LEAP       = 32'd366;
	localparam logic [31:0] YEAR_COMMON     = 32'd365;
	localparam logic [23:0] JUL_EPOCH_YEAR  = 24'd4712;
	localparam logic [23:0] ERA_YEARS       = 24'd400;
	localparam logic [23:0] CENT_YEARS      = 24'd100;
	localparam logic [23:0] CYCLE_YEARS     = 24'd4;
	localparam logic [3:0]  MAR_BASED_JAN   = 4'd10;
	localparam logic [3:0]  MAR_TO_CIVIL    = 4'd3;
	localparam logic [3:0]  JAN_TO_CIVIL    = 4'd9;
	localparam logic [3:0]  FEB_IDX         = 4'd1;

	// microprogram layout
	localparam pc_t A_WAIT   = 7'd0;
	localparam pc_t A_JDIV   = 7'd1;
	localparam pc_t A_JYEAR  = 7'd12;
	localparam pc_t A_JMON   = 7'd15;
	localparam pc_t A_FIN    = 7'd26;
	localparam pc_t A_GSHIFT = 7'd27;
	localparam pc_t A_GERA   = 7'd28;
	localparam pc_t A_GCENT  = 7'd43;
	localparam pc_t A_GGRP   = 7'd46;
	localparam pc_t A_GYEAR  = 7'd51;
	localparam pc_t A_GMON   = 7'd54;
	localparam pc_t A_GLAST  = 7'd64;

	// month lengths, january based and march based
	localparam logic [4:0] JUL_MLEN [0:10] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30};
	localparam logic [4:0] GREG_MLEN [0:10] = '{5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
		5'd30, 5'd31, 5'd30, 5'd31, 5'd31};

	typedef enum logic [2:0] {
		OP_WAIT = 3'b001,
		OP_CSUB = 3'b010,
		OP_FIN  = 3'b100
	} op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_FAIL,
		COND_ALWAYS
	} cond_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] k;
		logic [23:0] inc;
		logic        to_month;
		logic        feb;
		cond_t       cond;
		pc_t         tgt;
	} uword_t;

	typedef struct packed {
		logic load;
		logic step;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic pass;
		logic greg;
	} stat_t;

endpackage

// File: design/jd2cal_if.sv
`timescale 1ns / 1ps

interface jd2cal_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] day_number;

	modport source (output valid, output day_number, input ready);
	modport sink (input valid, input day_number, output ready);
endinterface

interface jd2cal_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [23:0] year_number;
	logic        before_christ;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, output before_christ, input ready);
	modport sink (input valid, input day_of_month, input month_number,
		input year_number, input before_christ, output ready);
endinterface

// File: design/jd2cal_ucode_rom.sv
`timescale 1ns / 1ps

module jd2cal_ucode_rom (
	input  jd2cal_pkg::pc_t    pc,
	output jd2cal_pkg::uword_t uw
);

	logic [3:0] jmon_idx;
	logic [3:0] gmon_idx;

	assign jmon_idx = 4'(pc - jd2cal_pkg::A_JMON);
	assign gmon_idx = 4'(pc - jd2cal_pkg::A_GMON);

	always_comb begin
		uw.op       = jd2cal_pkg::OP_CSUB;
		uw.k        = 32'd0;
		uw.inc      = 24'd0;
		uw.to_month = 1'b0;
		uw.feb      = 1'b0;
		uw.cond     = jd2cal_pkg::COND_NEXT;
		uw.tgt      = jd2cal_pkg::A_WAIT;
		unique case (pc) inside
			jd2cal_pkg::A_WAIT: begin
				uw.op  = jd2cal_pkg::OP_WAIT;
				uw.tgt = jd2cal_pkg::A_GSHIFT;
			end
			[jd2cal_pkg::A_JDIV:jd2cal_pkg::A_JYEAR-1]: begin
				// restoring division by 1461, one quotient bit per step
				uw.k   = jd2cal_pkg::JUL_CYCLE << 5'(jd2cal_pkg::A_JYEAR - pc - 7'd1);
				uw.inc = jd2cal_pkg::CYCLE_YEARS << 5'(jd2cal_pkg::A_JYEAR - pc - 7'd1);
			end
			[jd2cal_pkg::A_JYEAR:jd2cal_pkg::A_JMON-1]: begin
				// leap year leads the julian four-year cycle
				uw.k    = (pc == jd2cal_pkg::A_JYEAR) ? jd2cal_pkg::YEAR_LEAP
					: jd2cal_pkg::YEAR_COMMON;
				uw.inc  = 24'd1;
				uw.cond = jd2cal_pkg::COND_FAIL;
				uw.tgt  = jd2cal_pkg::A_JMON;
			end
			[jd2cal_pkg::A_JMON:jd2cal_pkg::A_FIN-1]: begin
				uw.k        = {27'd0, jd2cal_pkg::JUL_MLEN[jmon_idx]};
				uw.feb      = (jmon_idx == jd2cal_pkg::FEB_IDX);
				uw.to_month = 1'b1;
				uw.cond     = jd2cal_pkg::COND_FAIL;
				uw.tgt      = jd2cal_pkg::A_FIN;
			end
			jd2cal_pkg::A_FIN: begin
				uw.op  = jd2cal_pkg::OP_FIN;
				uw.tgt = jd2cal_pkg::A_WAIT;
			end
			jd2cal_pkg::A_GSHIFT: begin
				// rebase to 1 march of year 0
				uw.k = jd2cal_pkg::GREG_SHIFT;
			end
			[jd2cal_pkg::A_GERA:jd2cal_pkg::A_GCENT-1]: begin
				uw.k   = jd2cal_pkg::GREG_ERA << 5'(jd2cal_pkg::A_GCENT - pc - 7'd1);
				uw.inc = jd2cal_pkg::ERA_YEARS << 5'(jd2cal_pkg::A_GCENT - pc - 7'd1);
			end
			[jd2cal_pkg::A_GCENT:jd2cal_pkg::A_GGRP-1]: begin
				// at most three short centuries, the fourth keeps its leap day
				uw.k   = jd2cal_pkg::GREG_CENT;
				uw.inc = jd2cal_pkg::CENT_YEARS;
			end
			[jd2cal_pkg::A_GGRP:jd2cal_pkg::A_GYEAR-1]: begin
				uw.k   = jd2cal_pkg::JUL_CYCLE << 5'(jd2cal_pkg::A_GYEAR - pc - 7'd1);
				uw.inc = jd2cal_pkg::CYCLE_YEARS << 5'(jd2cal_pkg::A_GYEAR - pc - 7'd1);
			end
			[jd2cal_pkg::A_GYEAR:jd2cal_pkg::A_GMON-1]: begin
				uw.k   = jd2cal_pkg::YEAR_COMMON;
				uw.inc = 24'd1;
			end
			[jd2cal_pkg::A_GMON:jd2cal_pkg::A_GLAST]: begin
				// february is last in a march based year and is never subtracted
				uw.k        = {27'd0, jd2cal_pkg::GREG_MLEN[gmon_idx]};
				uw.to_month = 1'b1;
				uw.cond     = (pc == jd2cal_pkg::A_GLAST) ? jd2cal_pkg::COND_ALWAYS
					: jd2cal_pkg::COND_FAIL;
				uw.tgt      = jd2cal_pkg::A_FIN;
			end
			default: begin
				uw.cond = jd2cal_pkg::COND_ALWAYS;
			end
		endcase
	end

endmodule

// File: design/jd2cal_datapath.sv
`timescale 1ns / 1ps

module jd2cal_datapath (
	input  logic               clk,
	input  logic [31:0]        day_number,
	input  jd2cal_pkg::uword_t uw,
	input  jd2cal_pkg::ctl_t   ctl,
	output jd2cal_pkg::stat_t  stat,
	output logic [4:0]         day_of_month,
	output logic [3:0]         month_number,
	output logic [23:0]        year_number,
	output logic               before_christ
);

	logic [31:0] rem_q;
	logic [23:0] yr_q;
	logic [3:0]  mp_q;
	logic        greg_q;
	logic [4:0]  day_q;
	logic [3:0]  mon_q;
	logic [23:0] year_q;
	logic        bc_q;

	logic        leap;
	logic [31:0] k_eff;
	logic        pass;
	logic [4:0]  fin_day;
	logic [3:0]  fin_mon;
	logic [23:0] fin_year;
	logic        fin_bc;

	// julian leap years sit at year offsets divisible by four
	assign leap  = (yr_q[1:0] == 2'b00);
	assign k_eff = uw.k + {31'd0, uw.feb & leap};
	assign pass  = (rem_q >= k_eff);

	assign stat.pass = pass;
	assign stat.greg = (day_number > jd2cal_pkg::JULIAN_LAST_DAY);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= day_number;
			yr_q   <= 24'd0;
			mp_q   <= 4'd0;
			greg_q <= stat.greg;
		end else if (ctl.step && pass) begin
			rem_q <= rem_q - k_eff;
			if (uw.to_month) begin
				mp_q <= mp_q + 4'd1;
			end else begin
				yr_q <= yr_q + uw.inc;
			end
		end
	end

	always_comb begin
		fin_day = rem_q[4:0] + 5'd1;
		fin_bc  = 1'b0;
		if (greg_q) begin
			if (mp_q < jd2cal_pkg::MAR_BASED_JAN) begin
				fin_mon  = mp_q + jd2cal_pkg::MAR_TO_CIVIL;
				fin_year = yr_q;
			end else begin
				fin_mon  = mp_q - jd2cal_pkg::JAN_TO_CIVIL;
				fin_year = yr_q + 24'd1;
			end
		end else begin
			fin_mon = mp_q + 4'd1;
			if (yr_q <= jd2cal_pkg::JUL_EPOCH_YEAR) begin
				fin_bc   = 1'b1;
				fin_year = jd2cal_pkg::JUL_EPOCH_YEAR + 24'd1 - yr_q;
			end else begin
				fin_year = yr_q - jd2cal_pkg::JUL_EPOCH_YEAR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			day_q  <= fin_day;
			mon_q  <= fin_mon;
			year_q <= fin_year;
			bc_q   <= fin_bc;
		end
	end

	assign day_of_month  = day_q;
	assign month_number  = mon_q;
	assign year_number   = year_q;
	assign before_christ = bc_q;

endmodule

// File: design/julian_day_to_calendar_date_top.sv
// Converts a day count (0 is 1 January 4713 BC) into day, month, year and a BC
// flag: Julian calendar through 4 October 1582, Gregorian from 15 October 1582.
// One request is converted at a time by a microprogram of conditional
// subtractions on a single 32-bit subtractor and compare. A Julian date runs
// the four-year division, year and month steps, a Gregorian date the rebase,
// era, century, four-year, year and month steps; after its final step the
// program goes back to the wait step to take the next request. The finished
// result sits in an output register, so the next request is taken while it
// waits; the program stalls at its final step only if a second result is ready
// before the first has been taken.
`timescale 1ns / 1ps

module julian_day_to_calendar_date_top (
	input logic          clk,
	input logic          arst_n,
	jd2cal_in_if.sink    query,
	jd2cal_out_if.source result
);

	jd2cal_pkg::pc_t    pc_q;
	logic               out_v_q;
	jd2cal_pkg::uword_t uw;
	jd2cal_pkg::ctl_t   ctl;
	jd2cal_pkg::stat_t  stat;
	logic               accept;
	logic               fin_go;

	jd2cal_ucode_rom u_rom (
		.pc (pc_q),
		.uw (uw)
	);

	jd2cal_datapath u_dp (
		.clk           (clk),
		.day_number    (query.day_number),
		.uw            (uw),
		.ctl           (ctl),
		.stat          (stat),
		.day_of_month  (result.day_of_month),
		.month_number  (result.month_number),
		.year_number   (result.year_number),
		.before_christ (result.before_christ)
	);

	assign query.ready = (uw.op == jd2cal_pkg::OP_WAIT);
	assign accept      = query.valid && query.ready;
	assign fin_go      = (uw.op == jd2cal_pkg::OP_FIN) && (!out_v_q || result.ready);

	assign ctl.load = accept;
	assign ctl.step = (uw.op == jd2cal_pkg::OP_CSUB);
	assign ctl.fin  = fin_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= jd2cal_pkg::A_WAIT;
		end else begin
			unique case (uw.op)
				jd2cal_pkg::OP_WAIT: begin
					if (accept) begin
						pc_q <= stat.greg ? uw.tgt : pc_q + 7'd1;
					end
				end
				jd2cal_pkg::OP_CSUB: begin
					case (uw.cond)
						jd2cal_pkg::COND_NEXT:   pc_q <= pc_q + 7'd1;
						jd2cal_pkg::COND_FAIL:   pc_q <= stat.pass ? pc_q + 7'd1 : uw.tgt;
						jd2cal_pkg::COND_ALWAYS: pc_q <= uw.tgt;
						default:                 pc_q <= jd2cal_pkg::A_WAIT;
					endcase
				end
				jd2cal_pkg::OP_FIN: begin
					if (fin_go) begin
						pc_q <= uw.tgt;
					end
				end
				default: pc_q <= jd2cal_pkg::A_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fin_go) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign result.valid = out_v_q;

endmodule

// File: design/jd2cal_checker.sv
`timescale 1ns / 1ps

module jd2cal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        q_valid,
	input logic        q_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic [4:0]  r_day,
	input logic [3:0]  r_month,
	input logic [23:0] r_year,
	input logic        r_bc
);

	// a stalled result keeps its data
	assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_day) && $stable(r_month)
			&& $stable(r_year) && $stable(r_bc))
		else $error("result changed while stalled");

	// one request at a time: no acceptance right after an acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> !q_ready)
		else $error("request taken back to back");

	// a new result only comes while a conversion is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!q_ready))
		else $error("result without a conversion");

	// every shown date has a nonzero day and year and a month from 1 to 12
	assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_day != 5'd0 && r_month != 4'd0 && r_month <= 4'd12
			&& r_year != 24'd0)
		else $error("malformed date");

endmodule

bind julian_day_to_calendar_date_top jd2cal_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.q_valid (query.valid),
	.q_ready (query.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_day   (result.day_of_month),
	.r_month (result.month_number),
	.r_year  (result.year_number),
	.r_bc    (result.before_christ)
);

// File: bench/jd2cal_date_check.sv
`timescale 1ns / 1ps

module jd2cal_date_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  logic        q_ready,
	input  logic [31:0] q_day,
	input  logic        r_valid,
	input  logic        r_ready,
	input  logic [4:0]  r_day,
	input  logic [3:0]  r_month,
	input  logic [23:0] r_year,
	input  logic        r_bc,
	output int unsigned date_errors,
	output int unsigned dates_pending
);

	localparam longint unsigned JULIAN_END   = 64'd2299160;
	localparam longint unsigned FOUR_YEARS   = 64'd1461;
	localparam longint          FIRST_ASTRO  = -64'sd4712;
	localparam longint unsigned MARCH_ZERO   = 64'd1721120;
	localparam longint unsigned ERA_DAYS     = 64'd146097;
	localparam int unsigned     MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
		31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [23:0] year;
		logic        bc;
	} calendar_date_t;

	calendar_date_t dates_due [$];

	function automatic calendar_date_t civil_date_of(input logic [31:0] count);
		longint unsigned n, cycles, rem, yr_off, doy, z, era, doe, yoe, mp;
		longint          astro;
		int unsigned     m, mlen;
		bit              leap;
		calendar_date_t  d;
		n = count;
		d.bc = 1'b0;
		if (n <= JULIAN_END) begin
			cycles = n / FOUR_YEARS;
			rem = n % FOUR_YEARS;
			// first year of each four-year block is the leap one
			if (rem < 366) begin
				yr_off = 0;
				doy = rem;
				leap = 1'b1;
			end else begin
				yr_off = 1 + (rem - 366) / 365;
				doy = (rem - 366) % 365;
				leap = 1'b0;
			end
			astro = FIRST_ASTRO + longint'(4 * cycles + yr_off);
			m = 0;
			while (m < 11) begin
				mlen = MONTH_DAYS[m] + ((m == 1 && leap) ? 1 : 0);
				if (doy < mlen)
					break;
				doy = doy - mlen;
				m++;
			end
			d.month = 4'(m + 1);
			d.day = 5'(doy + 1);
			// astronomical year 0 is 1 BC
			if (astro <= 0) begin
				d.year = 24'(1 - astro);
				d.bc = 1'b1;
			end else begin
				d.year = 24'(astro);
			end
		end else begin
			// gregorian, years starting on 1 march
			z = n - MARCH_ZERO;
			era = z / ERA_DAYS;
			doe = z % ERA_DAYS;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			d.day = 5'(doy - (153 * mp + 2) / 5 + 1);
			d.month = 4'(mp < 10 ? mp + 3 : mp - 9);
			d.year = 24'(yoe + era * 400 + ((mp >= 10) ? 1 : 0));
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		calendar_date_t want, seen;
		if (!arst_n) begin
			dates_due.delete();
			dates_pending = 0;
		end else begin
			if (q_valid && q_ready)
				dates_due.push_back(civil_date_of(q_day));
			if (r_valid && r_ready) begin
				seen = '{day: r_day, month: r_month, year: r_year, bc: r_bc};
				if (dates_due.size() == 0) begin
					date_errors++;
					if (date_errors <= 10)
						$display("%0t unexpected date %0d/%0d/%0d bc=%0d", $realtime,
							seen.day, seen.month, seen.year, seen.bc);
				end else begin
					want = dates_due.pop_front();
					if (want != seen) begin
						date_errors++;
						if (date_errors <= 10)
							$display("%0t date mismatch: got %0d/%0d/%0d bc=%0d, want %0d/%0d/%0d bc=%0d",
								$realtime, seen.day, seen.month, seen.year, seen.bc,
								want.day, want.month, want.year, want.bc);
					end
				end
			end
			dates_pending = dates_due.size();
		end
	end

endmodule

// File: bench/julian_day_to_calendar_date_top_test.sv
`timescale 1ns / 1ps

module julian_day_to_calendar_date_top_test;

	localparam int unsigned DAY_COUNT    = 1650;
	localparam int unsigned TAIL_ITEMS   = 200;
	localparam int unsigned HOLD_AT      = 300;
	localparam int unsigned HOLD_CYCLES  = 500;
	localparam int unsigned DRAIN_AT     = 800;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned EDGE_COUNT   = 25;
	localparam logic [31:0] SWITCH_DAY   = 32'd2299160;

	localparam logic [31:0] EDGE_DAYS [EDGE_COUNT] = '{
		32'd0, 32'd1, 32'd58, 32'd59, 32'd60, 32'd365, 32'd366, 32'd1460, 32'd1461,
		32'd1721423, 32'd1721424, 32'd2299159, 32'd2299160, 32'd2299161, 32'd2299162,
		32'd2415079, 32'd2415080, 32'd2451604, 32'd2451605,
		32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        hold_results = 1'b0;
	logic        idle_off = 1'b0;
	int unsigned stall_left = 0;
	int unsigned days_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned date_errors;
	int unsigned dates_pending;

	jd2cal_in_if  query_ch ();
	jd2cal_out_if result_ch ();

	julian_day_to_calendar_date_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch)
	);

	jd2cal_date_check check (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (query_ch.valid),
		.q_ready       (query_ch.ready),
		.q_day         (query_ch.day_number),
		.r_valid       (result_ch.valid),
		.r_ready       (result_ch.ready),
		.r_day         (result_ch.day_of_month),
		.r_month       (result_ch.month_number),
		.r_year        (result_ch.year_number),
		.r_bc          (result_ch.before_christ),
		.date_errors   (date_errors),
		.dates_pending (dates_pending)
	);

	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		query_ch.valid = 1'b0;
		query_ch.day_number = '0;
		result_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[julian_day_to_calendar_date_top] ERROR");
			$finish;
		end
	end

	// result side: short random stalls, plus one long hold-off below
	always @(negedge clk) begin
		if (hold_results) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!idle_off && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// long hold-off so the block fills and stalls the request side
	initial begin
		wait (days_sent >= HOLD_AT);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	task automatic offer_day(input logic [31:0] count);
		query_ch.valid <= 1'b1;
		query_ch.day_number <= count;
		do
			@(posedge clk);
		while (!query_ch.ready);
		days_sent++;
		@(negedge clk);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			query_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] random_day();
		logic [31:0] count;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: count = $urandom_range(0, SWITCH_DAY);
			4:          count = $urandom_range(SWITCH_DAY - 800, SWITCH_DAY + 800);
			5, 6:       count = $urandom_range(SWITCH_DAY + 1, 32'd9999999);
			default:    count = $urandom;
		endcase
		return count;
	endfunction

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < EDGE_COUNT; i++)
			offer_day(EDGE_DAYS[i]);

		for (int i = EDGE_COUNT; i < DAY_COUNT; i++) begin
			// calm stretch mid run and a calm tail
			idle_off <= (i >= 1000 && i < 1150) || (i >= DAY_COUNT - TAIL_ITEMS);
			if (i == DRAIN_AT) begin
				query_ch.valid <= 1'b0;
				while (dates_pending != 0)
					@(negedge clk);
				@(negedge clk);
			end
			offer_day(random_day());
		end

		query_ch.valid <= 1'b0;
		while (dates_pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		if (date_errors == 0)
			$display("[julian_day_to_calendar_date_top] OK");
		else
			$display("[julian_day_to_calendar_date_top] ERROR");
		$finish;
	end

endmodule
